>>> hdl/kbdfifo_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kbdfifo_pkg
// Shared constants, types and set-1 keymap lookups for the scancode decoder.
// ---------------------------------------------------------------------------
package kbdfifo_pkg;

   localparam int FIFO_DEPTH = 256;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CHAR_W     = 7;

   // output queue between the RAM read stage and the response port
   localparam int OBUF_DEPTH = 4;
   localparam int OBUF_PTR_W = $clog2(OBUF_DEPTH);
   localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

   // request kinds carried on req_tuser
   localparam logic OP_SCANCODE = 1'b0;
   localparam logic OP_READ     = 1'b1;

   localparam logic [7:0] SC_EXTENDED = 8'hE0;
   localparam logic [6:0] SC_LSHIFT   = 7'h2A;
   localparam logic [6:0] SC_RSHIFT   = 7'h36;
   localparam logic [6:0] SC_CAPS     = 7'h3A;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] character;
   } push_type;

   typedef struct packed {
      logic              char_valid;
      logic [CHAR_W-1:0] character;
   } rsp_item_type;

   // US layout, set 1 make code -> ASCII; 0 means no character
   function automatic logic [CHAR_W-1:0] key_lookup(input logic [6:0] code,
                                                    input logic shifted);
      logic [CHAR_W-1:0] ch;
      ch = '0;
      unique case (code)
         7'h01: ch = 7'h1B;
         7'h02: ch = shifted ? 7'h21 : 7'h31;
         7'h03: ch = shifted ? 7'h40 : 7'h32;
         7'h04: ch = shifted ? 7'h23 : 7'h33;
         7'h05: ch = shifted ? 7'h24 : 7'h34;
         7'h06: ch = shifted ? 7'h25 : 7'h35;
         7'h07: ch = shifted ? 7'h5E : 7'h36;
         7'h08: ch = shifted ? 7'h26 : 7'h37;
         7'h09: ch = shifted ? 7'h2A : 7'h38;
         7'h0A: ch = shifted ? 7'h28 : 7'h39;
         7'h0B: ch = shifted ? 7'h29 : 7'h30;
         7'h0C: ch = shifted ? 7'h5F : 7'h2D;
         7'h0D: ch = shifted ? 7'h2B : 7'h3D;
         7'h0E: ch = 7'h08;
         7'h0F: ch = 7'h09;
         7'h10: ch = shifted ? 7'h51 : 7'h71;
         7'h11: ch = shifted ? 7'h57 : 7'h77;
         7'h12: ch = shifted ? 7'h45 : 7'h65;
         7'h13: ch = shifted ? 7'h52 : 7'h72;
         7'h14: ch = shifted ? 7'h54 : 7'h74;
         7'h15: ch = shifted ? 7'h59 : 7'h79;
         7'h16: ch = shifted ? 7'h55 : 7'h75;
         7'h17: ch = shifted ? 7'h49 : 7'h69;
         7'h18: ch = shifted ? 7'h4F : 7'h6F;
         7'h19: ch = shifted ? 7'h50 : 7'h70;
         7'h1A: ch = shifted ? 7'h7B : 7'h5B;
         7'h1B: ch = shifted ? 7'h7D : 7'h5D;
         7'h1C: ch = 7'h0A;
         7'h1E: ch = shifted ? 7'h41 : 7'h61;
         7'h1F: ch = shifted ? 7'h53 : 7'h73;
         7'h20: ch = shifted ? 7'h44 : 7'h64;
         7'h21: ch = shifted ? 7'h46 : 7'h66;
         7'h22: ch = shifted ? 7'h47 : 7'h67;
         7'h23: ch = shifted ? 7'h48 : 7'h68;
         7'h24: ch = shifted ? 7'h4A : 7'h6A;
         7'h25: ch = shifted ? 7'h4B : 7'h6B;
         7'h26: ch = shifted ? 7'h4C : 7'h6C;
         7'h27: ch = shifted ? 7'h3A : 7'h3B;
         7'h28: ch = shifted ? 7'h22 : 7'h27;
         7'h29: ch = shifted ? 7'h7E : 7'h60;
         7'h2B: ch = shifted ? 7'h7C : 7'h5C;
         7'h2C: ch = shifted ? 7'h5A : 7'h7A;
         7'h2D: ch = shifted ? 7'h58 : 7'h78;
         7'h2E: ch = shifted ? 7'h43 : 7'h63;
         7'h2F: ch = shifted ? 7'h56 : 7'h76;
         7'h30: ch = shifted ? 7'h42 : 7'h62;
         7'h31: ch = shifted ? 7'h4E : 7'h6E;
         7'h32: ch = shifted ? 7'h4D : 7'h6D;
         7'h33: ch = shifted ? 7'h3C : 7'h2C;
         7'h34: ch = shifted ? 7'h3E : 7'h2E;
         7'h35: ch = shifted ? 7'h3F : 7'h2F;
         7'h39: ch = 7'h20;
         // keypad
         7'h47: ch = 7'h37;
         7'h48: ch = 7'h38;
         7'h49: ch = 7'h39;
         7'h4A: ch = 7'h2D;
         7'h4B: ch = 7'h34;
         7'h4C: ch = 7'h35;
         7'h4D: ch = 7'h36;
         7'h4E: ch = 7'h2B;
         7'h4F: ch = 7'h31;
         7'h50: ch = 7'h32;
         7'h51: ch = 7'h33;
         7'h52: ch = 7'h30;
         7'h53: ch = 7'h2E;
         default: ch = '0;
      endcase
      return ch;
   endfunction

endpackage

>>> hdl/kbdfifo_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kbdfifo_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module kbdfifo_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/kbdfifo_decode.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kbdfifo_decode
// Set-1 scancode decoder: shift / caps lock tracking and keymap lookup.
// ---------------------------------------------------------------------------
module kbdfifo_decode
   import kbdfifo_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     code_en,     // scancode transaction with output-full set
   input  logic [7:0] scan_code,
   output push_type push
);

   logic lshift_ff, lshift_in;
   logic rshift_ff, rshift_in;
   logic caps_ff,   caps_in;

   logic              shifted;
   logic [CHAR_W-1:0] raw_char;
   logic [CHAR_W-1:0] fixed_char;
   logic              is_lower;
   logic              is_upper;

   assign shifted  = lshift_ff | rshift_ff;
   assign raw_char = key_lookup(scan_code[6:0], shifted);
   assign is_lower = (raw_char >= 7'h61) && (raw_char <= 7'h7A);
   assign is_upper = (raw_char >= 7'h41) && (raw_char <= 7'h5A);

   // caps lock flips case of letters only; bit 5 is the case bit
   always_comb begin
      fixed_char = raw_char;
      if (caps_ff && ((!shifted && is_lower) || (shifted && is_upper))) begin
         fixed_char = raw_char ^ 7'h20;
      end
   end

   always_comb begin
      lshift_in      = lshift_ff;
      rshift_in      = rshift_ff;
      caps_in        = caps_ff;
      push.valid     = 1'b0;
      push.character = fixed_char;
      if (code_en && (scan_code != SC_EXTENDED)) begin
         if (scan_code[7]) begin
            if (scan_code[6:0] == SC_LSHIFT) lshift_in = 1'b0;
            if (scan_code[6:0] == SC_RSHIFT) rshift_in = 1'b0;
         end else if (scan_code[6:0] == SC_LSHIFT) begin
            lshift_in = 1'b1;
         end else if (scan_code[6:0] == SC_RSHIFT) begin
            rshift_in = 1'b1;
         end else if (scan_code[6:0] == SC_CAPS) begin
            caps_in = ~caps_ff;
         end else begin
            push.valid = (fixed_char != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lshift_ff <= 1'b0;
         rshift_ff <= 1'b0;
         caps_ff   <= 1'b0;
      end else begin
         lshift_ff <= lshift_in;
         rshift_ff <= rshift_in;
         caps_ff   <= caps_in;
      end
   end

endmodule

>>> hdl/kbdfifo_outbuf.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kbdfifo_outbuf
// Small response queue decoupling the read pipeline from rsp backpressure.
// ---------------------------------------------------------------------------
module kbdfifo_outbuf
   import kbdfifo_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rsp_item_type          push_item,
   input  logic                  pop,
   output logic                  not_empty,
   output rsp_item_type          head,
   output logic [OBUF_CNT_W-1:0] count
);

   rsp_item_type            entry_ff [OBUF_DEPTH];
   logic [OBUF_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [OBUF_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [OBUF_CNT_W-1:0]   count_ff,  count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

>>> hdl/keyboard_scancode_to_ascii_fifo_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyboard_scancode_to_ascii_fifo_unit
// PS/2 set-1 scancode decoder feeding a character FIFO, with a read channel.
// ---------------------------------------------------------------------------
// Usage:
//  - req channel: tuser = 0 delivers a scancode byte, tuser = 1 asks for one
//    character. A scancode is acted on only with the output-full bit set.
//    Scancode transactions produce no response.
//  - rsp channel: one transaction per read request, in request order.
//    tuser = 1 with the oldest character in tdata, or tuser = 0 and tdata = 0
//    when the FIFO was empty.
//  - A read response passes through the request register, the RAM read
//    register and the output queue before it appears on rsp.
//  - Throughput: one request per cycle while req_tready is high. The FIFO
//    RAM has one write port, for scancodes, and one read port, for reads.
//  - Backpressure: a 4-entry output queue absorbs reads in flight. req_tready
//    drops when the queue plus the reads in flight fill it, so a stalled
//    response side stops the request side after four outstanding reads.
//  - FIFO holds FIFO_DEPTH-1 characters; further characters are dropped.
//  - Reset (synchronous): shift and caps lock released, FIFO emptied, queue
//    flushed. RAM contents are not cleared; no clearing pass is needed.
// ---------------------------------------------------------------------------
module keyboard_scancode_to_ascii_fifo_unit
   import kbdfifo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [0] output_full, [8:1] scan_code, rest zero
   input  logic [0:0]  req_tuser,   // [0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] character, [7] zero
   output logic [0:0]  rsp_tuser    // [0] char_valid
);

   // request register
   logic       s1_valid_ff;
   logic       s1_op_ff;
   logic       s1_full_ff;
   logic [7:0] s1_code_ff;

   // RAM read stage
   logic s2_valid_ff, s2_valid_in;
   logic s2_hit_ff,   s2_hit_in;

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic [PTR_W-1:0] rd_ptr_next;

   logic              req_accept;
   logic              s1_read;
   logic              fifo_empty;
   logic              ram_we;
   logic [CHAR_W-1:0] ram_rdata;
   push_type          dec_push;

   rsp_item_type              s2_item;
   rsp_item_type              obuf_head;
   logic                      obuf_not_empty;
   logic [OBUF_CNT_W-1:0]     obuf_count;
   logic [OBUF_CNT_W-1:0]     in_flight;

   // reads in flight plus queued responses must fit the output queue
   assign s1_read    = s1_valid_ff && (s1_op_ff == OP_READ);
   assign in_flight  = obuf_count + OBUF_CNT_W'(s1_read) + OBUF_CNT_W'(s2_valid_ff);
   assign req_tready = (in_flight < OBUF_CNT_W'(OBUF_DEPTH));
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= req_tuser[0];
         s1_full_ff <= req_tdata[0];
         s1_code_ff <= req_tdata[8:1];
      end
   end

   kbdfifo_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .code_en   (s1_valid_ff && (s1_op_ff == OP_SCANCODE) && s1_full_ff),
      .scan_code (s1_code_ff),
      .push      (dec_push)
   );

   // character FIFO pointer control
   assign wr_ptr_next = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_next = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign fifo_empty  = (wr_ptr_ff == rd_ptr_ff);
   assign ram_we      = dec_push.valid && (wr_ptr_next != rd_ptr_ff);

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      s2_valid_in = s1_read;
      s2_hit_in   = s1_read && !fifo_empty;
      if (ram_we) begin
         wr_ptr_in = wr_ptr_next;
      end
      if (s1_read && !fifo_empty) begin
         rd_ptr_in = rd_ptr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         s2_valid_ff <= 1'b0;
         s2_hit_ff   <= 1'b0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         s2_valid_ff <= s2_valid_in;
         s2_hit_ff   <= s2_hit_in;
      end
   end

   kbdfifo_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (FIFO_DEPTH)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (dec_push.character),
      .rd_en   (s1_read),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   // empty reads return zero
   assign s2_item.char_valid = s2_hit_ff;
   assign s2_item.character  = s2_hit_ff ? ram_rdata : '0;

   kbdfifo_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_item (s2_item),
      .pop       (rsp_tvalid && rsp_tready),
      .not_empty (obuf_not_empty),
      .head      (obuf_head),
      .count     (obuf_count)
   );

   assign rsp_tvalid   = obuf_not_empty;
   assign rsp_tdata    = {1'b0, obuf_head.character};
   assign rsp_tuser[0] = obuf_head.char_valid;

endmodule
